// ----- rtl/core/ilid_pkg.sv -----
`timescale 1ns / 1ps
package ilid_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int ELEM_W_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // tdata layouts, byte padded
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic hit;
  } cell_ctl_t;

  // levels of a 4-ary reduction tree over n leaves
  function automatic int tree_levels(int n);
    int lv;
    int span;
    lv   = 1;
    span = 4;
    while (span < n) begin
      span = span * 4;
      lv   = lv + 1;
    end
    return lv;
  endfunction

endpackage

// ----- rtl/core/ilid_cell.sv -----
`timescale 1ns / 1ps
module ilid_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 6,
  parameter int EW    = 32
) (
  input  logic               clk,
  input  ilid_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]      pos,
  input  logic [EW-1:0]      val,
  input  logic [EW-1:0]      left,
  input  logic [EW-1:0]      right,
  output logic [EW-1:0]      q,
  output logic [EW-1:0]      leaf
);
  import ilid_pkg::*;

  localparam logic [PW-1:0] ME = PW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (pos == ME) begin
        q <= val;
      end else if (pos < ME) begin
        q <= left;
      end
    end else if (ctl.del && pos <= ME) begin
      q <= right;
    end
  end

  assign leaf = (ctl.hit && pos == ME) ? q : '0;

endmodule

// ----- rtl/core/ilid_or_tree.sv -----
`timescale 1ns / 1ps
module ilid_or_tree #(
  parameter int N = 64,
  parameter int W = 32,
  parameter int L = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);
  import ilid_pkg::*;

  localparam int INT = ((4 ** L) - 1) / 3;

  logic [W-1:0] node [INT];

  for (genvar j = 0; j < INT; j++) begin : g_node
    logic [W-1:0] kid [4];
    for (genvar k = 0; k < 4; k++) begin : g_kid
      localparam int C = 4 * j + 1 + k;
      if (C < INT) begin : g_int
        assign kid[k] = node[C];
      end else if (C - INT < N) begin : g_leaf
        assign kid[k] = leaf[C - INT];
      end else begin : g_pad
        assign kid[k] = '0;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        node[j] <= kid[0] | kid[1] | kid[2] | kid[3];
      end
    end
  end

  assign root = node[0];

endmodule

// ----- rtl/core/indexed_list_insert_delete.sv -----
`timescale 1ns / 1ps
// Ordered list held in a row of DEPTH cells.
// Input stream s_*: one command word per handshake (insert at, remove at,
// read at, push back, pop back). Output stream m_*: one result word per
// command, in order: returned element, status, length after the command.
// Every cell decides its next content in the cycle a command is accepted,
// so an insert or remove shifts the whole row at once and a new command can
// be taken every cycle unless the output stalls.
// The returned element is gathered from the cells by a registered 4-ary OR
// tree of tree_levels(DEPTH) levels; a result is valid on m_* once its
// command has passed every tree level. The tree root is the output
// register.
// When m_tready is low with a result waiting, the whole result pipe and the
// input stall together (s_tready low); nothing is lost or repeated.
// Reset empties the list and the result pipe; cell contents are not cleared
// and are never read before they are written.
module indexed_list_insert_delete #(
  parameter int DEPTH         = ilid_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = ilid_pkg::ELEM_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // command[2:0], index[9:3], value[41:10], zero pad
  input  logic [ilid_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // read_value[31:0], status[33:32], length[40:34], zero pad
  output logic [ilid_pkg::M_TDATA_W-1:0] m_tdata
);
  import ilid_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;
  localparam int L  = tree_levels(DEPTH);

  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] val_in;
  logic [63:0]      val_wide;
  logic [EW-1:0]    elem_in;

  assign cmd      = s_tdata[2:0];
  assign idx      = s_tdata[9:3];
  assign val_in   = s_tdata[41:10];
  assign val_wide = 64'(val_in);
  assign elem_in  = val_wide[EW-1:0];

  logic advance;
  logic acc;
  logic [L-1:0] pv;

  assign advance  = !pv[L-1] || m_tready;
  assign s_tready = advance;
  assign acc      = s_tvalid && advance;

  logic [LW-1:0] len;
  logic [LW-1:0] len_next;
  logic [LW-1:0] len_dec;
  logic [CW-1:0] idx_x;
  logic [CW-1:0] len_x;
  logic          full;
  logic          ins;
  logic          del;
  logic          hit;
  logic [PW-1:0] pos;
  logic [STAT_W-1:0] st;
  cell_ctl_t     ctl;

  assign idx_x   = CW'(idx);
  assign len_x   = CW'(len);
  assign len_dec = len - LW'(1);
  assign full    = (len == LW'(DEPTH));

  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    hit      = 1'b0;
    pos      = '0;
    st       = ST_OK;
    len_next = len;
    unique case (cmd)
      CMD_INSERT: begin
        if (idx_x > len_x) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ins      = 1'b1;
          pos      = idx_x[PW-1:0];
          len_next = len + LW'(1);
        end
      end
      CMD_REMOVE: begin
        if (idx_x >= len_x) begin
          st = ST_RANGE;
        end else begin
          del      = 1'b1;
          hit      = 1'b1;
          pos      = idx_x[PW-1:0];
          len_next = len_dec;
        end
      end
      CMD_READ: begin
        if (idx_x >= len_x) begin
          st = ST_RANGE;
        end else begin
          hit = 1'b1;
          pos = idx_x[PW-1:0];
        end
      end
      CMD_PUSH: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins      = 1'b1;
          pos      = len[PW-1:0];
          len_next = len + LW'(1);
        end
      end
      CMD_POP: begin
        if (len == '0) begin
          st = ST_RANGE;
        end else begin
          del      = 1'b1;
          hit      = 1'b1;
          pos      = len_dec[PW-1:0];
          len_next = len_dec;
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  assign ctl.ins = ins && acc;
  assign ctl.del = del && acc;
  assign ctl.hit = hit && acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (acc) begin
      len <= len_next;
    end
  end

  logic [EW-1:0] q    [DEPTH];
  logic [EW-1:0] leaf [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] left;
    logic [EW-1:0] right;
    if (i == 0) begin : g_first
      assign left = elem_in;
    end else begin : g_mid_l
      assign left = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = q[i];
    end else begin : g_mid_r
      assign right = q[i+1];
    end
    ilid_cell #(
      .INDEX (i),
      .PW    (PW),
      .EW    (EW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos),
      .val   (elem_in),
      .left  (left),
      .right (right),
      .q     (q[i]),
      .leaf  (leaf[i])
    );
  end

  logic [EW-1:0] root;

  ilid_or_tree #(
    .N (DEPTH),
    .W (EW),
    .L (L)
  ) u_tree (
    .clk  (clk),
    .en   (advance),
    .leaf (leaf),
    .root (root)
  );

  logic [STAT_W-1:0] st_pipe  [L];
  logic [LEN_W-1:0]  len_pipe [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (advance) begin
      pv <= L'({pv, acc});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_pipe[0]  <= st;
      len_pipe[0] <= LEN_W'(len_next);
      for (int s = 1; s < L; s++) begin
        st_pipe[s]  <= st_pipe[s-1];
        len_pipe[s] <= len_pipe[s-1];
      end
    end
  end

  logic [63:0] root_wide;

  assign root_wide = 64'(root);
  assign m_tvalid  = pv[L-1];
  assign m_tdata   = {7'd0, len_pipe[L-1], st_pipe[L-1], root_wide[VAL_W-1:0]};

endmodule

// ----- rtl/core/ilid_checker.sv -----
`timescale 1ns / 1ps
module ilid_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ilid_pkg::M_TDATA_W-1:0] m_tdata
);
  import ilid_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] == ST_OK || m_tdata[33:32] == ST_RANGE ||
                  m_tdata[33:32] == ST_FULL))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == '0)
    else $error("error result carries data");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
